@@ rtl/hfe_pkg.sv @@
// hfe_pkg: shared types and constants of the HDLC frame encoder.
// No dependencies; imported by hfe_front, hfe_back and the top level.
`timescale 1ns / 1ps

package hfe_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0]  HDLC_FLAG = 8'h7E;
  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [15:0] CRC_SEED  = 16'hFFFF;
  localparam logic [5:0]  EMIT_CAP  = 6'd48;

  // One queued request: message byte plus its classification.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       first;
  } hfe_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FLAG_OPEN,
    S_DATA,
    S_CRC,
    S_STUFF,
    S_FLAG_CLOSE,
    S_PAD
  } hfe_state_e;

endpackage

@@ rtl/hdlc_frame_encoder_core.sv @@
// hdlc_frame_encoder_core: top level of the HDLC framer (flag, CRC-16,
// zero stuffing, pad). Depends on hfe_pkg, hfe_front and hfe_back.
//
//   channel   direction  handshake         payload
//   input     in         push / full       data_byte_i, last_byte_i
//   result    out        empty / pop       out_bit_o, frame_end_o
//
// The sequencer sends one frame bit per cycle while the result is not stalled: a
// mid-frame byte sends its 8 data bits plus one per stuffed zero; a first byte adds 8
// flag bits; a last byte adds 16 CRC bits, stuffed zeros, 8 flag bits and the pad.
// An idle sequencer loads a byte as soon as the queue holds one; bits past the 48th drop.
// Reset clears queue and sequencer; a stalled result holds and the sequencer
// waits, while the queue keeps taking bytes until full.
`timescale 1ns / 1ps

module hdlc_frame_encoder_core import hfe_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic       out_bit_o,
  output logic       frame_end_o
);

  hfe_item_t item;
  logic      item_valid;
  logic      item_take;
  logic      back_idle;

  hfe_front #(
    .QueueDepth(QueueDepth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .item_o      (item),
    .item_valid_o(item_valid),
    .item_take_i (item_take)
  );

  hfe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item),
    .item_valid_i(item_valid),
    .item_take_o (item_take),
    .back_idle_o (back_idle),
    .empty       (empty),
    .pop         (pop),
    .out_bit_o   (out_bit_o),
    .frame_end_o (frame_end_o)
  );

`ifndef SYNTH
  // the frame always ends on a zero: last flag bit or a pad bit
  a_end_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && frame_end_o) |-> !out_bit_o)
    else $error("frame end on a one bit");

  a_idle_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (back_idle && item_valid) |=> !back_idle)
    else $error("sequencer ignored a queued request");

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (back_idle && !item_valid) |=> back_idle)
    else $error("sequencer started without a request");
`endif

endmodule

@@ rtl/hfe_front.sv @@
// hfe_front: accepts message bytes, marks the first byte of each frame and
// queues them for the bit sequencer. Depends on hfe_pkg.
`timescale 1ns / 1ps

module hfe_front import hfe_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output hfe_item_t  item_o,
  output logic       item_valid_o,
  input  logic       item_take_i
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  hfe_item_t            slot_q [QueueDepth];
  logic [PtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 in_frame_q, in_frame_d;
  logic                 push_acc, take;
  hfe_item_t            wr_item;

  assign full         = (cnt_q == CntW'(QueueDepth));
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = slot_q[rd_ptr_q];
  assign push_acc     = push & ~full;
  assign take         = item_take_i & item_valid_o;

  always_comb begin
    wr_item.data  = data_byte_i;
    wr_item.last  = last_byte_i;
    wr_item.first = ~in_frame_q;

    wr_ptr_d   = wr_ptr_q;
    rd_ptr_d   = rd_ptr_q;
    cnt_d      = cnt_q;
    in_frame_d = in_frame_q;
    if (push_acc) begin
      wr_ptr_d   = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      // a last byte closes the frame; the next byte opens a new one
      in_frame_d = ~last_byte_i;
    end
    if (take) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_acc, take})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      cnt_q      <= '0;
      in_frame_q <= 1'b0;
    end else begin
      wr_ptr_q   <= wr_ptr_d;
      rd_ptr_q   <= rd_ptr_d;
      cnt_q      <= cnt_d;
      in_frame_q <= in_frame_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_acc) begin
      slot_q[wr_ptr_q] <= wr_item;
    end
  end

endmodule

@@ rtl/hfe_back.sv @@
// hfe_back: bit sequencer; sends flags, data, CRC, stuffed zeros and pad one
// bit per cycle into the output register while it is not stalled. Depends on hfe_pkg.
`timescale 1ns / 1ps

module hfe_back import hfe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  hfe_item_t item_i,
  input  logic      item_valid_i,
  output logic      item_take_o,
  output logic      back_idle_o,
  output logic      empty,
  input  logic      pop,
  output logic      out_bit_o,
  output logic      frame_end_o
);

  hfe_state_e  state_q, state_d;
  hfe_state_e  ret_state_q, ret_state_d;
  logic [3:0]  idx_q, idx_d;
  logic [3:0]  ret_idx_q, ret_idx_d;
  logic        ret_done_q, ret_done_d;
  logic [15:0] crc_q, crc_d;
  logic [2:0]  ones_q, ones_d;
  logic [2:0]  phase_q, phase_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [7:0]  byte_q, byte_d;
  logic        last_q, last_d;
  logic        out_valid_q, out_valid_d;
  logic        out_bit_q, out_bit_d;
  logic        out_end_q, out_end_d;

  logic        capped, advance, emit, item_done, load;
  logic        sbit, send, stuffed, need_stuff, fb;
  hfe_state_e  cont_state;
  logic [3:0]  cont_idx;
  logic        cont_done;
  logic [2:0]  pad_len;

  assign capped      = (cnt_q == EMIT_CAP);
  assign advance     = (state_q != S_IDLE) && (capped || !out_valid_q || pop);
  assign emit        = advance && !capped;
  assign pad_len     = 3'd0 - phase_q;
  assign empty       = ~out_valid_q;
  assign out_bit_o   = out_bit_q;
  assign frame_end_o = out_end_q;
  assign back_idle_o = (state_q == S_IDLE);
  assign item_take_o = load;

  always_comb begin
    state_d     = state_q;
    ret_state_d = ret_state_q;
    idx_d       = idx_q;
    ret_idx_d   = ret_idx_q;
    ret_done_d  = ret_done_q;
    crc_d       = crc_q;
    ones_d      = ones_q;
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    byte_d      = byte_q;
    last_d      = last_q;
    sbit        = 1'b0;
    send        = 1'b0;
    stuffed     = 1'b0;
    need_stuff  = 1'b0;
    item_done   = 1'b0;
    cont_state  = state_q;
    cont_idx    = idx_q;
    cont_done   = 1'b0;
    fb          = crc_q[15] ^ byte_q[idx_q[2:0]];

    if (advance) begin
      unique case (state_q)
        S_FLAG_OPEN: begin
          sbit = HDLC_FLAG[3'd7 - idx_q[2:0]];
          if (idx_q == 4'd7) begin
            state_d = S_DATA;
            idx_d   = '0;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
        S_DATA: begin
          sbit    = byte_q[idx_q[2:0]];
          stuffed = 1'b1;
          crc_d   = {crc_q[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
          if (idx_q == 4'd7) begin
            cont_idx = '0;
            if (last_q) begin
              cont_state = S_CRC;
            end else begin
              cont_done = 1'b1;
            end
          end else begin
            cont_idx = idx_q + 1'b1;
          end
        end
        S_CRC: begin
          sbit    = ~crc_q[15];
          stuffed = 1'b1;
          crc_d   = {crc_q[14:0], 1'b0};
          if (idx_q == 4'd15) begin
            cont_state = S_FLAG_CLOSE;
            cont_idx   = '0;
          end else begin
            cont_idx = idx_q + 1'b1;
          end
        end
        S_STUFF: begin
          sbit    = 1'b0;
          phase_d = phase_q + 1'b1;
          if (ret_done_q) begin
            item_done = 1'b1;
          end else begin
            state_d = ret_state_q;
            idx_d   = ret_idx_q;
          end
        end
        S_FLAG_CLOSE: begin
          sbit = HDLC_FLAG[3'd7 - idx_q[2:0]];
          if (idx_q == 4'd7) begin
            idx_d = '0;
            if (phase_q == 3'd0) begin
              send      = 1'b1;
              item_done = 1'b1;
            end else begin
              state_d = S_PAD;
            end
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
        S_PAD: begin
          sbit = 1'b0;
          if (idx_q[2:0] == pad_len - 3'd1) begin
            send      = 1'b1;
            item_done = 1'b1;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
        default: begin
          sbit = 1'b0;
        end
      endcase

      // zero stuffing over data and CRC bits
      if (stuffed) begin
        phase_d = phase_q + 1'b1;
        if (sbit) begin
          if (ones_q >= 3'd4) begin
            need_stuff = 1'b1;
            ones_d     = '0;
          end else begin
            ones_d = ones_q + 1'b1;
          end
        end else begin
          ones_d = '0;
        end
        if (need_stuff) begin
          state_d     = S_STUFF;
          ret_state_d = cont_state;
          ret_idx_d   = cont_idx;
          ret_done_d  = cont_done;
        end else if (cont_done) begin
          item_done = 1'b1;
        end else begin
          state_d = cont_state;
          idx_d   = cont_idx;
        end
      end

      if (emit) begin
        cnt_d = cnt_q + 1'b1;
      end
      if (item_done) begin
        state_d = S_IDLE;
      end
    end

    // take the next request in the cycle the current one finishes
    load = ((state_q == S_IDLE) || item_done) && item_valid_i;
    if (load) begin
      state_d = item_i.first ? S_FLAG_OPEN : S_DATA;
      idx_d   = '0;
      cnt_d   = '0;
      byte_d  = item_i.data;
      last_d  = item_i.last;
      if (item_i.first) begin
        crc_d   = CRC_SEED;
        ones_d  = '0;
        phase_d = '0;
      end
    end

    out_valid_d = (out_valid_q & ~pop) | emit;
    out_bit_d   = emit ? sbit : out_bit_q;
    out_end_d   = emit ? send : out_end_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_state_q <= S_IDLE;
      ret_done_q  <= 1'b0;
      idx_q       <= '0;
      ret_idx_q   <= '0;
      crc_q       <= CRC_SEED;
      ones_q      <= '0;
      phase_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_state_q <= ret_state_d;
      ret_done_q  <= ret_done_d;
      idx_q       <= idx_d;
      ret_idx_q   <= ret_idx_d;
      crc_q       <= crc_d;
      ones_q      <= ones_d;
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q    <= byte_d;
    last_q    <= last_d;
    out_bit_q <= out_bit_d;
    out_end_q <= out_end_d;
  end

endmodule
